[rtl/xpd_pkg.sv]
// xpd_pkg: shared types and constants for the xor packet deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package xpd_pkg;

  localparam int PAYLOAD_CAPACITY = 32;
  localparam int IDX_W            = $clog2(PAYLOAD_CAPACITY);
  localparam int CNT_W            = $clog2(PAYLOAD_CAPACITY + 1);
  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 8;
  localparam int SLEN_W           = 6;
  localparam int CFG_IDX_W        = 2;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hAA;
  localparam logic [BYTE_W-1:0] ACK_RESET    = 8'h11;
  localparam logic [BYTE_W-1:0] SENSOR_RESET = 8'h13;
  localparam logic [SLEN_W-1:0] SLEN_RESET   = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE      = 2'd0,
    CFG_ACK_COMMAND    = 2'd1,
    CFG_SENSOR_COMMAND = 2'd2,
    CFG_SENSOR_LENGTH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] ack_command;
    logic [BYTE_W-1:0] sensor_command;
    logic [SLEN_W-1:0] sensor_length;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COMMAND,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_SENSOR = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_ACK,
    REQ_ERR,
    REQ_SENSOR
  } req_op_t;

  typedef struct packed {
    req_op_t           op;
    logic [BYTE_W-1:0] command;
    logic [CNT_W-1:0]  count;
  } emit_req_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_FETCH,
    EM_SEND
  } em_state_t;

endpackage

`default_nettype wire

[rtl/xpd_payload_ram.sv]
// xpd_payload_ram: payload byte store, one write and one registered read port.
// Depends on xpd_pkg.
`default_nettype none

module xpd_payload_ram
  import xpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [PAYLOAD_CAPACITY];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/xpd_parser.sv]
// xpd_parser: frame parser; tracks phase, command, length and running xor,
// writes payload bytes into the store and posts result requests. Uses xpd_pkg.
`default_nettype none

module xpd_parser
  import xpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   in_check,
  output logic                   wr_en,
  output logic      [IDX_W-1:0]  wr_addr,
  output logic      [BYTE_W-1:0] wr_data,
  output emit_req_t              req
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;

  logic [CNT_W-1:0]  count_inc;
  logic              has_room;
  logic              sum_ok;

  assign count_inc = count_r + CNT_W'(1);
  assign has_room  = (count_r < CNT_W'(PAYLOAD_CAPACITY));
  assign sum_ok    = (rx_byte == xor_r);
  assign in_check  = (phase_r == PH_CHECK);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (rx_byte == cfg.sync_byte) phase_nxt = PH_COMMAND;
        end
        PH_COMMAND: phase_nxt = PH_LENGTH;
        PH_LENGTH: begin
          phase_nxt = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (!has_room) phase_nxt = PH_IDLE;
          else if (LEN_W'(count_inc) >= len_r) phase_nxt = PH_CHECK;
        end
        PH_CHECK: phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[IDX_W-1:0];
    wr_data     = rx_byte;
    req.op      = REQ_NONE;
    req.command = cmd_r;
    req.count   = count_r;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_COMMAND: begin
          cmd_nxt = rx_byte;
          xor_nxt = rx_byte;
        end
        PH_LENGTH: begin
          len_nxt   = rx_byte;
          xor_nxt   = xor_r ^ rx_byte;
          count_nxt = '0;
        end
        PH_PAYLOAD: begin
          if (has_room) begin
            wr_en     = 1'b1;
            xor_nxt   = xor_r ^ rx_byte;
            count_nxt = count_inc;
          end else begin
            cmd_nxt   = '0;
            len_nxt   = '0;
            count_nxt = '0;
            xor_nxt   = '0;
          end
        end
        PH_CHECK: begin
          if (!sum_ok) begin
            req.op = REQ_ERR;
          end else if (cmd_r == cfg.ack_command && len_r != '0) begin
            req.op = REQ_ACK;
          end else if (cmd_r == cfg.sensor_command &&
                       len_r == LEN_W'(cfg.sensor_length) && count_r != '0) begin
            req.op = REQ_SENSOR;
          end
          cmd_nxt   = '0;
          len_nxt   = '0;
          count_nxt = '0;
          xor_nxt   = '0;
        end
        default: begin
          cmd_nxt   = '0;
          len_nxt   = '0;
          count_nxt = '0;
          xor_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= '0;
      len_r   <= '0;
      count_r <= '0;
      xor_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/xpd_emitter.sv]
// xpd_emitter: result output register and payload replay sequencer that
// reads the payload store. Uses xpd_pkg.
`default_nettype none

module xpd_emitter
  import xpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire emit_req_t         req,
  output logic                   busy,
  output logic                   rd_en,
  output logic      [IDX_W-1:0]  rd_addr,
  input  wire logic [BYTE_W-1:0] rd_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        out_kind,
  output logic      [BYTE_W-1:0] out_frame_command,
  output logic      [BYTE_W-1:0] out_data_byte,
  output logic                   out_last
);

  em_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;

  logic              ov_r, ov_nxt;
  kind_t             kind_r, kind_nxt;
  logic [BYTE_W-1:0] ocmd_r, ocmd_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              last_r, last_nxt;

  logic              out_free;
  logic              load;
  logic              last_item;
  logic [CNT_W-1:0]  idx_inc;

  assign out_free  = !ov_r || !out_stall;
  assign load      = (state_r == EM_SEND) && out_free;
  assign idx_inc   = idx_r + CNT_W'(1);
  assign last_item = (idx_inc == cnt_r);
  assign busy      = (state_r != EM_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      EM_IDLE: begin
        if (req.op == REQ_SENSOR) state_nxt = EM_FETCH;
      end
      EM_FETCH: state_nxt = EM_SEND;
      EM_SEND: begin
        if (load && last_item) state_nxt = EM_IDLE;
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    cmd_nxt  = cmd_r;
    rd_en    = 1'b0;
    rd_addr  = idx_r[IDX_W-1:0];
    ov_nxt   = ov_r && out_stall;
    kind_nxt = kind_r;
    ocmd_nxt = ocmd_r;
    data_nxt = data_r;
    last_nxt = last_r;
    unique case (state_r)
      EM_IDLE: begin
        case (req.op) inside
          REQ_ACK, REQ_ERR: begin
            ov_nxt   = 1'b1;
            kind_nxt = (req.op == REQ_ACK) ? KIND_ACK : KIND_ERROR;
            ocmd_nxt = req.command;
            data_nxt = '0;
            last_nxt = 1'b1;
          end
          REQ_SENSOR: begin
            idx_nxt = '0;
            cnt_nxt = req.count;
            cmd_nxt = req.command;
          end
          default: ;
        endcase
      end
      EM_FETCH: begin
        rd_en = 1'b1;
      end
      EM_SEND: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (load) begin
          ov_nxt   = 1'b1;
          kind_nxt = KIND_SENSOR;
          ocmd_nxt = cmd_r;
          data_nxt = rd_data;
          last_nxt = last_item;
          idx_nxt  = idx_inc;
          rd_en    = !last_item;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    cmd_r  <= cmd_nxt;
    kind_r <= kind_nxt;
    ocmd_r <= ocmd_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = ov_r;
  assign out_kind          = kind_r;
  assign out_frame_command = ocmd_r;
  assign out_data_byte     = data_r;
  assign out_last          = last_r;

  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (req.op != REQ_NONE) |-> (state_r == EM_IDLE))
    else $error("result request while replay active");

  a_single_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (req.op == REQ_ACK || req.op == REQ_ERR) |-> !ov_r)
    else $error("single result request with output register full");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_SEND) |-> (idx_r < cnt_r))
    else $error("replay index past count");

  a_fetch_to_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == EM_FETCH) |=> (state_r == EM_SEND))
    else $error("fetch not followed by send");

endmodule

`default_nettype wire

[rtl/xor_packet_deframer_unit.sv]
// xor_packet_deframer_unit: top level; configuration registers, parser,
// payload store and result emitter. Uses xpd_pkg and all xpd_* modules.
// Ack and checksum-error results appear in the cycle after the checksum byte;
// sensor replay goes via fetch and send, then one payload byte per unstalled cycle.
// Throughput: one byte per cycle; in_stall is high while a replay reads the store
// and while a checksum byte waits for the output register to drain.
// Reset: synchronous, active low; parser idle, output empty, registers at defaults.
`default_nettype none

module xor_packet_deframer_unit
  import xpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [1:0]           out_kind,
  output logic      [BYTE_W-1:0]    out_frame_command,
  output logic      [BYTE_W-1:0]    out_data_byte,
  output logic                      out_last
);

  cfg_t              cfg_r, cfg_nxt;
  emit_req_t         req;
  logic              accept;
  logic              in_check;
  logic              emit_busy;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_BYTE:      cfg_nxt.sync_byte      = cfg_data;
        CFG_ACK_COMMAND:    cfg_nxt.ack_command    = cfg_data;
        CFG_SENSOR_COMMAND: cfg_nxt.sensor_command = cfg_data;
        CFG_SENSOR_LENGTH:  cfg_nxt.sensor_length  = cfg_data[SLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte      <= SYNC_RESET;
      cfg_r.ack_command    <= ACK_RESET;
      cfg_r.sensor_command <= SENSOR_RESET;
      cfg_r.sensor_length  <= SLEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = emit_busy || (in_check && out_valid);
  assign accept   = in_valid && !in_stall;

  xpd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .in_check (in_check),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .req      (req)
  );

  xpd_payload_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xpd_emitter u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .busy              (emit_busy),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_frame_command (out_frame_command),
    .out_data_byte     (out_data_byte),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
